FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL. Each macro expects
// signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/irc_tok_pkg.sv
// ----------------------------------------------------------------------------
// IRC line tokenizer package
// Request types, parse phases, role/status/event codes and the command
// classification tables shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  // Most parameters a line may carry before it is flagged.
  localparam logic [3:0] MAX_PARAMS = 4'd15;

  // Characters with a meaning in the line grammar.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Byte roles.
  localparam logic [2:0] ROLE_SEP     = 3'd0;
  localparam logic [2:0] ROLE_NICK    = 3'd1;
  localparam logic [2:0] ROLE_USER    = 3'd2;
  localparam logic [2:0] ROLE_HOST    = 3'd3;
  localparam logic [2:0] ROLE_CMD     = 3'd4;
  localparam logic [2:0] ROLE_MIDDLE  = 3'd5;
  localparam logic [2:0] ROLE_TRAIL   = 3'd6;
  localparam logic [2:0] ROLE_DROP_CR = 3'd7;

  // Line status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;
  localparam logic [1:0] STATUS_TOO_MANY  = 2'd3;

  // Event kinds.
  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_PING        = 4'd1;
  localparam logic [3:0] EV_PONG        = 4'd2;
  localparam logic [3:0] EV_PRIVMSG     = 4'd3;
  localparam logic [3:0] EV_JOIN        = 4'd4;
  localparam logic [3:0] EV_PART        = 4'd5;
  localparam logic [3:0] EV_QUIT        = 4'd6;
  localparam logic [3:0] EV_NICK        = 4'd7;
  localparam logic [3:0] EV_MODE        = 4'd8;
  localparam logic [3:0] EV_KICK        = 4'd9;
  localparam logic [3:0] EV_KNOWN_NUM   = 4'd10;
  localparam logic [3:0] EV_UNKNOWN_NUM = 4'd11;
  localparam logic [3:0] EV_UNKNOWN_CMD = 4'd12;

  // Error flag bits.
  localparam int ERR_MALFORMED_BIT = 0;
  localparam int ERR_TOO_MANY_BIT  = 1;

  // Command buffer depth and the saturation point of the length counter.
  localparam int         CMD_DEPTH   = 7;
  localparam logic [3:0] CMD_LEN_MAX = 4'd8;

  // Parse phases.
  typedef enum logic [3:0] {
    PH_START,
    PH_PFX_FIRST,
    PH_PFX,
    PH_CMD_FIRST,
    PH_CMD,
    PH_GAP,
    PH_MIDDLE,
    PH_TRAIL,
    PH_SINK
  } phase_t;

  // Part of the prefix being read.
  typedef enum logic [1:0] {
    PART_NICK,
    PART_USER,
    PART_HOST
  } part_t;

  // First bytes of the command, byte 0 at index 0.
  typedef logic [CMD_DEPTH-1:0][7:0] cmd_buf_t;

  // Input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  // Result request.
  typedef struct packed {
    logic [2:0] role;
    logic [3:0] param_index;
    logic       line_end;
    logic [1:0] status;
    logic [3:0] event_kind;
    logic [9:0] numeric_code;
    logic [3:0] param_count;
    logic       prefix_present;
  } out_item_t;

  // Named commands; the text is right-aligned, first character highest.
  localparam int NUM_CMDS = 9;
  localparam logic [55:0] CMD_NAME [NUM_CMDS] = '{
    "PING", "PONG", "PRIVMSG", "JOIN", "PART", "QUIT", "NICK", "MODE", "KICK"
  };
  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
    4'd4, 4'd4, 4'd7, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
  };
  localparam logic [3:0] CMD_KIND [NUM_CMDS] = '{
    EV_PING, EV_PONG, EV_PRIVMSG, EV_JOIN, EV_PART, EV_QUIT, EV_NICK, EV_MODE,
    EV_KICK
  };
  localparam logic CMD_NEEDS_PFX [NUM_CMDS] = '{
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  // Numeric replies the block recognizes.
  localparam int NUM_KNOWN = 30;
  localparam logic [9:0] KNOWN_CODES [NUM_KNOWN] = '{
    10'd1,   10'd2,   10'd3,   10'd4,   10'd5,   10'd221, 10'd251, 10'd252,
    10'd253, 10'd254, 10'd255, 10'd311, 10'd312, 10'd313, 10'd317, 10'd318,
    10'd319, 10'd324, 10'd331, 10'd332, 10'd333, 10'd341, 10'd353, 10'd366,
    10'd372, 10'd375, 10'd376, 10'd401, 10'd403, 10'd433
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic code_known(logic [9:0] code);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KNOWN; k++) begin
      if (code == KNOWN_CODES[k]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Classify a finished command. The first named command that matches wins.
  function automatic logic [3:0] event_of(cmd_buf_t cmd, logic [3:0] len,
                                          logic had_pfx, logic [9:0] code);
    logic [3:0] kind;
    logic       hit;
    logic       match;
    kind = EV_UNKNOWN_CMD;
    hit  = 1'b0;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      match = (len == CMD_LEN[k]) && (!CMD_NEEDS_PFX[k] || had_pfx);
      for (int i = 0; i < CMD_DEPTH; i++) begin
        if (i < int'(CMD_LEN[k])) begin
          if (cmd[i] != CMD_NAME[k][(int'(CMD_LEN[k]) - 1 - i) * 8 +: 8]) begin
            match = 1'b0;
          end
        end
      end
      if (match) begin
        kind = CMD_KIND[k];
        hit  = 1'b1;
      end
    end
    if (!hit && len == 4'd3 && is_digit(cmd[0]) && is_digit(cmd[1]) &&
        is_digit(cmd[2])) begin
      kind = code_known(code) ? EV_KNOWN_NUM : EV_UNKNOWN_NUM;
    end
    return kind;
  endfunction

endpackage

FILE: design/irc_line_tokenizer_core.sv
// ----------------------------------------------------------------------------
// IRC line tokenizer core
// Tags each byte of an IRC line with its role and summarizes the line on its
// last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of one line enter on the in_ channel, one per request, with last set
//   on the final byte. Every input request produces exactly one result request
//   on the out_ channel carrying the byte's role and parameter index; the
//   result of the last byte also carries status, event kind, numeric code,
//   parameter count and the prefix flag.
//   A request is taken at a rising edge where valid is high and stall is low.
//   The byte lands in the input register, and the result register is written
//   while the parse state updates. Throughput is one byte per cycle while
//   out_stall is low, set by the parse state update between the input
//   register and the result register.
//   When out_stall is held, the result register keeps its request. An empty
//   input register takes one more byte; once it is full, in_stall is high in
//   the same cycle, following out_stall combinationally.
//   Reset (rst_n low at a clock edge) empties both registers and returns the
//   parser to the start of a line. The parser also returns to line start
//   after every last byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irc_line_tokenizer_core
  import irc_tok_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Pipeline registers.
  logic      in_valid_r;
  in_item_t  in_r;
  logic      out_valid_r;
  out_item_t out_r;

  // Parse state.
  phase_t     phase_r,     phase_nxt;
  part_t      part_r,      part_nxt;
  logic       had_pfx_r,   had_pfx_nxt;
  logic [3:0] pcnt_r,      pcnt_nxt;
  logic [3:0] cmd_len_r,   cmd_len_nxt;
  logic [9:0] code_r,      code_nxt;
  logic [1:0] err_r,       err_nxt;
  cmd_buf_t   cmd_buf_r;
  cmd_buf_t   cmd_view;

  logic      adv;
  logic      in_take;
  logic      do_cmd;
  logic      do_fail;
  logic      do_open;
  logic      open_trail;
  logic      do_pfx;
  logic      cmd_wr;
  logic      is_numeric;
  logic [7:0] c;
  out_item_t res;

  // Handshake: the stage moves when the result register is free or drains.
  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign c         = in_r.data_byte;
  assign cmd_wr    = do_cmd && (cmd_len_r < 4'(CMD_DEPTH));

  // Per-byte parse step and line summary.
  always_comb begin
    phase_nxt   = phase_r;
    part_nxt    = part_r;
    had_pfx_nxt = had_pfx_r;
    pcnt_nxt    = pcnt_r;
    cmd_len_nxt = cmd_len_r;
    code_nxt    = code_r;
    err_nxt     = err_r;
    do_cmd      = 1'b0;
    do_fail     = 1'b0;
    do_open     = 1'b0;
    open_trail  = 1'b0;
    do_pfx      = 1'b0;
    is_numeric  = 1'b0;
    res         = '0;
    res.role    = ROLE_SEP;

    if (c == CH_CR && in_r.last) begin
      res.role = ROLE_DROP_CR;
    end else begin
      unique case (phase_r)
        PH_START: begin
          if (c == CH_COLON) begin
            had_pfx_nxt = 1'b1;
            phase_nxt   = PH_PFX_FIRST;
          end else if (c == CH_SPACE) begin
            do_fail = 1'b1;
          end else begin
            do_cmd = 1'b1;
          end
        end
        PH_PFX_FIRST: begin
          if (c == CH_SPACE) begin
            do_fail = 1'b1;
          end else begin
            phase_nxt = PH_PFX;
            do_pfx    = 1'b1;
          end
        end
        PH_PFX: begin
          if (c == CH_SPACE) phase_nxt = PH_CMD_FIRST;
          else               do_pfx    = 1'b1;
        end
        PH_CMD_FIRST: begin
          if (c == CH_SPACE || c == CH_COLON) do_fail = 1'b1;
          else                                do_cmd  = 1'b1;
        end
        PH_CMD: begin
          if (c == CH_SPACE) phase_nxt = PH_GAP;
          else               do_cmd    = 1'b1;
        end
        PH_GAP: begin
          if (c != CH_SPACE) begin
            do_open    = 1'b1;
            open_trail = (c == CH_COLON);
          end
        end
        PH_MIDDLE: begin
          if (c == CH_SPACE) begin
            phase_nxt = PH_GAP;
          end else begin
            res.role        = ROLE_MIDDLE;
            res.param_index = pcnt_r - 4'd1;
          end
        end
        PH_TRAIL: begin
          res.role        = ROLE_TRAIL;
          res.param_index = pcnt_r - 4'd1;
        end
        default: begin
          res.role = ROLE_SEP;
        end
      endcase
    end

    // Prefix: '!' opens the user part, '@' the host part.
    if (do_pfx) begin
      unique case (part_r)
        PART_NICK: begin
          if (c == CH_BANG)    part_nxt = PART_USER;
          else if (c == CH_AT) part_nxt = PART_HOST;
          else                 res.role = ROLE_NICK;
        end
        PART_USER: begin
          if (c == CH_AT) part_nxt = PART_HOST;
          else            res.role = ROLE_USER;
        end
        default: begin
          res.role = ROLE_HOST;
        end
      endcase
    end

    // Command byte: the first three digits build the numeric code.
    if (do_cmd) begin
      if (cmd_len_r < 4'd3 && is_digit(c)) begin
        code_nxt = 10'((code_r << 3) + (code_r << 1) + 10'(c - CH_ZERO));
      end
      if (cmd_len_r < CMD_LEN_MAX) cmd_len_nxt = cmd_len_r + 4'd1;
      phase_nxt = PH_CMD;
      res.role  = ROLE_CMD;
    end

    // Opening a parameter; past the limit the rest of the line is dropped.
    if (do_open) begin
      if (pcnt_r >= MAX_PARAMS) begin
        err_nxt[ERR_TOO_MANY_BIT] = 1'b1;
        phase_nxt = PH_SINK;
      end else begin
        res.param_index = open_trail ? 4'd0 : pcnt_r;
        res.role        = open_trail ? ROLE_SEP : ROLE_MIDDLE;
        pcnt_nxt        = pcnt_r + 4'd1;
        phase_nxt       = open_trail ? PH_TRAIL : PH_MIDDLE;
      end
    end

    if (do_fail) begin
      err_nxt[ERR_MALFORMED_BIT] = 1'b1;
      phase_nxt = PH_SINK;
    end

    // Command buffer as it stands after this byte.
    cmd_view = cmd_buf_r;
    if (cmd_wr) cmd_view[cmd_len_r[2:0]] = c;

    // Line summary on the last byte.
    res.line_end = in_r.last;
    if (in_r.last) begin
      if (phase_nxt == PH_START) begin
        res.status = STATUS_EMPTY;
      end else if (err_nxt[ERR_MALFORMED_BIT] || phase_nxt == PH_PFX_FIRST ||
                   phase_nxt == PH_PFX || phase_nxt == PH_CMD_FIRST) begin
        res.status = STATUS_MALFORMED;
      end else begin
        res.status         = err_nxt[ERR_TOO_MANY_BIT] ? STATUS_TOO_MANY : STATUS_OK;
        res.event_kind     = event_of(cmd_view, cmd_len_nxt, had_pfx_nxt, code_nxt);
        is_numeric         = (res.event_kind == EV_KNOWN_NUM) ||
                             (res.event_kind == EV_UNKNOWN_NUM);
        res.numeric_code   = is_numeric ? code_nxt : 10'd0;
        res.param_count    = pcnt_nxt;
        res.prefix_present = had_pfx_nxt;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take || (in_valid_r && !adv);
    end
    if (in_take) in_r <= in_data;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (adv) out_r <= res;
  end

  // Parse state; every last byte returns it to line start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      part_r    <= PART_NICK;
      had_pfx_r <= 1'b0;
      pcnt_r    <= 4'd0;
      cmd_len_r <= 4'd0;
      code_r    <= 10'd0;
      err_r     <= 2'd0;
    end else if (adv) begin
      if (in_r.last) begin
        phase_r   <= PH_START;
        part_r    <= PART_NICK;
        had_pfx_r <= 1'b0;
        pcnt_r    <= 4'd0;
        cmd_len_r <= 4'd0;
        code_r    <= 10'd0;
        err_r     <= 2'd0;
      end else begin
        phase_r   <= phase_nxt;
        part_r    <= part_nxt;
        had_pfx_r <= had_pfx_nxt;
        pcnt_r    <= pcnt_nxt;
        cmd_len_r <= cmd_len_nxt;
        code_r    <= code_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  // Command buffer, written as command bytes arrive.
  always_ff @(posedge clk) begin
    if (adv && cmd_wr) cmd_buf_r[cmd_len_r[2:0]] <= c;
  end

  // Summary fields stay clear on results that do not close a line.
  `IRC_ASSERT_SAME(a_summary_clear, out_valid_r && !out_r.line_end,
    out_r.status == STATUS_OK && out_r.event_kind == EV_NONE &&
    out_r.numeric_code == 10'd0 && out_r.param_count == 4'd0 &&
    !out_r.prefix_present, "summary fields set on a mid-line result")

  // A dropped carriage return only ever closes a line.
  `IRC_ASSERT_SAME(a_cr_closes, out_valid_r && out_r.role == ROLE_DROP_CR,
    out_r.line_end, "dropped CR on a byte that does not end the line")

  // Too many parameters always reports the full count.
  `IRC_ASSERT_SAME(a_too_many_count,
    out_valid_r && out_r.status == STATUS_TOO_MANY,
    out_r.param_count == MAX_PARAMS, "too-many status with a short count")

  // The parser is back at line start after a last byte is processed.
  `IRC_ASSERT_NEXT(a_line_restart, adv && in_r.last,
    phase_r == PH_START && pcnt_r == 4'd0 && err_r == 2'd0 && !had_pfx_r,
    "parse state not cleared after the last byte")

endmodule
